[hw/rtl/implicit_array_bst_assert.svh]
// assertion macros for the implicit array search tree
`ifndef IMPLICIT_ARRAY_BST_ASSERT_SVH
`define IMPLICIT_ARRAY_BST_ASSERT_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define IAB_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// condition must never be true out of reset
`define IAB_ASSERT_NEVER(name, clk, rst_n, cond) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");
`else
`define IAB_ASSERT(name, clk, rst_n, prop)
`define IAB_ASSERT_NEVER(name, clk, rst_n, cond)
`endif

`endif

[hw/rtl/iabst_pkg.sv]
package iabst_pkg;

  localparam int LEVELS_DEF    = 10;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int IN_KEY_W      = 32;
  localparam int TREE_H_W      = 4;

  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_PRESENT   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_NO_ROOM   = 2'd3
  } status_e;

  typedef struct packed {
    logic                       mode;
    logic signed [IN_KEY_W-1:0] key;
  } in_item_t;

  typedef struct packed {
    logic [1:0]          status;
    logic [TREE_H_W-1:0] tree_height;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic clr_step;
    logic start;
    logic step;
    logic emit;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clr_last;
    logic walk_done;
  } dp_sts_t;

endpackage

[hw/rtl/iabst_ctrl.sv]
module iabst_ctrl
  import iabst_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  input  dp_sts_t   sts_i,
  output ctrl_cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_EMIT
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    cmd_o          = '0;
    cmd_o.clr_step = (state_q == S_CLEAR);
    cmd_o.start    = (state_q == S_IDLE) && in_valid_i;
    cmd_o.step     = (state_q == S_WALK);
    cmd_o.emit     = (state_q == S_EMIT) && out_free;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_CLEAR: begin
          if (sts_i.clr_last) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) state_q <= S_WALK;
        end
        S_WALK: begin
          if (sts_i.walk_done) state_q <= S_EMIT;
        end
        S_EMIT: begin
          if (out_free) state_q <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[hw/rtl/iabst_dpath.sv]
module iabst_dpath
  import iabst_pkg::*;
#(
  parameter int LEVELS    = LEVELS_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  in_item_i,
  output out_item_t out_item_o,
  input  ctrl_cmd_t cmd_i,
  output dp_sts_t   sts_o
);

  localparam int SLOTS = 1 << LEVELS;
  localparam int IDX_W = LEVELS;
  localparam int LVL_W = $clog2(LEVELS + 1);

  logic [KEY_WIDTH-1:0] key_mem   [SLOTS];
  logic                 valid_mem [SLOTS];

  logic [KEY_WIDTH-1:0] key_in;
  logic [KEY_WIDTH-1:0] key_q;
  logic                 mode_q;
  logic [IDX_W-1:0]     idx_q, idx_d;
  logic [LVL_W-1:0]     lvl_q;
  logic [LVL_W-1:0]     height_q;
  logic [IDX_W-1:0]     clr_q;
  logic [1:0]           res_q, res_d;
  out_item_t            out_q;

  logic [KEY_WIDTH-1:0] key_rd_q;
  logic                 valid_rd_q;

  logic hit, lt, last_lvl, walk_done, descend, wr_en;
  logic [IDX_W-1:0]          vwr_addr;
  logic [TREE_H_W+LVL_W-1:0] height_ext;

  // key narrowed or sign-extended to the stored width
  if (KEY_WIDTH <= IN_KEY_W) begin : g_key_trunc
    assign key_in = in_item_i.key[KEY_WIDTH-1:0];
  end else begin : g_key_ext
    assign key_in = {{(KEY_WIDTH-IN_KEY_W){in_item_i.key[IN_KEY_W-1]}}, in_item_i.key};
  end

  assign hit       = (key_q == key_rd_q);
  assign lt        = ($signed(key_q) < $signed(key_rd_q));
  assign last_lvl  = (lvl_q == LVL_W'(LEVELS));
  assign walk_done = !valid_rd_q || hit || last_lvl;
  assign descend   = cmd_i.step && !walk_done;
  assign wr_en     = cmd_i.step && !valid_rd_q && (mode_q == MODE_INSERT);

  always_comb begin
    if (!valid_rd_q) begin
      res_d = (mode_q == MODE_SEARCH) ? ST_NOT_FOUND : ST_INSERTED;
    end else if (hit) begin
      res_d = ST_PRESENT;
    end else begin
      res_d = (mode_q == MODE_SEARCH) ? ST_NOT_FOUND : ST_NO_ROOM;
    end
  end

  // next slot: root on a new item, child while walking
  always_comb begin
    idx_d = idx_q;
    if (cmd_i.start) begin
      idx_d = IDX_W'(1);
    end else if (descend) begin
      idx_d = {idx_q[IDX_W-2:0], ~lt};
    end
  end

  assign vwr_addr = cmd_i.clr_step ? clr_q : idx_q;

  always_ff @(posedge clk_i) begin
    key_rd_q   <= key_mem[idx_d];
    valid_rd_q <= valid_mem[idx_d];
    if (wr_en) key_mem[idx_q] <= key_q;
    if (cmd_i.clr_step || wr_en) valid_mem[vwr_addr] <= !cmd_i.clr_step;
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d;
    if (cmd_i.start) begin
      key_q  <= key_in;
      mode_q <= in_item_i.mode;
      lvl_q  <= LVL_W'(1);
    end else if (descend) begin
      lvl_q <= lvl_q + LVL_W'(1);
    end
    if (cmd_i.step && walk_done) res_q <= res_d;
    if (cmd_i.emit) begin
      out_q.status      <= res_q;
      out_q.tree_height <= height_ext[TREE_H_W-1:0];
    end
  end

  assign height_ext = {{TREE_H_W{1'b0}}, height_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      height_q <= '0;
      clr_q    <= '0;
    end else begin
      if (wr_en && (lvl_q > height_q)) height_q <= lvl_q;
      if (cmd_i.clr_step) clr_q <= clr_q + IDX_W'(1);
    end
  end

  assign sts_o.clr_last  = &clr_q;
  assign sts_o.walk_done = walk_done;
  assign out_item_o      = out_q;

endmodule

[hw/rtl/implicit_array_bst.sv]
// channel | direction | handshake             | payload
// in      | input     | in_valid_i/in_stall_o   | in_item_i  (mode, key)
// out     | output    | out_valid_o/out_stall_i | out_item_o (status, tree_height)
//
// an item visits k tree levels (1 <= k <= LEVELS), one level per cycle, set by the
// single key memory read port
// after reset a clearing pass wipes every slot of the occupancy store with
// in_stall_o high
// one finished item waits in the output register while the next item is accepted;
// a stalled output holds the walk in its final state only

`include "implicit_array_bst_assert.svh"

module implicit_array_bst
  import iabst_pkg::*;
#(
  parameter int LEVELS    = LEVELS_DEF,
  parameter int KEY_WIDTH = KEY_WIDTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // sequencer: clearing pass, accept, walk, load of the result
  iabst_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // key and occupancy stores, compare, slot and height tracking
  iabst_dpath #(
    .LEVELS    (LEVELS),
    .KEY_WIDTH (KEY_WIDTH)
  ) u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_item_i  (in_item_i),
    .out_item_o (out_item_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

  // a new item never starts while the occupancy store is being wiped
  `IAB_ASSERT_NEVER(a_no_start_in_clear, clk_i, rst_ni, cmd.start && cmd.clr_step)
  // once an item is taken the input side stalls during its walk
  `IAB_ASSERT(a_stall_after_accept, clk_i, rst_ni, (in_valid_i && !in_stall_o) |=> in_stall_o)
  // loading a result always presents it on the next cycle
  `IAB_ASSERT(a_emit_shows_item, clk_i, rst_ni, cmd.emit |=> out_valid_o)

endmodule
